// ===== hdl/bcje_pkg.sv =====
// Shared types and codes of the bytecode compare/jump execute core.
// Used by bcje_exec, the core top level and the testbench; depends on nothing.
`default_nettype none

package bcje_pkg;

  // Instruction kinds
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_MOVE   = 4'd2;
  localparam logic [3:0] OP_CMP    = 4'd3;
  localparam logic [3:0] OP_JMP    = 4'd4;
  localparam logic [3:0] OP_JMP_F  = 4'd5;
  localparam logic [3:0] OP_JMP_T  = 4'd6;
  localparam logic [3:0] OP_RETURN = 4'd7;

  // Compare types
  localparam logic [3:0] CT_BOOL   = 4'd0;
  localparam logic [3:0] CT_S64    = 4'd4;
  localparam logic [3:0] CT_HANDLE = 4'd9;

  // Relations
  localparam logic [2:0] REL_LT = 3'd0;
  localparam logic [2:0] REL_LE = 3'd1;
  localparam logic [2:0] REL_EQ = 3'd2;
  localparam logic [2:0] REL_NE = 3'd3;
  localparam logic [2:0] REL_GE = 3'd4;
  localparam logic [2:0] REL_GT = 3'd5;

  localparam logic [7:0] BOOL_KIND_RESET = 8'd1;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  compare_type;
    logic [2:0]  relation;
    logic [7:0]  dest_index;
    logic [7:0]  src_index;
    logic [63:0] operand_c;
    logic [15:0] current_pc;
  } instr_t;

  // One register file entry: kind code over payload
  typedef struct packed {
    logic [7:0]  kind;
    logic [63:0] payload;
  } operand_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        halted;
    logic        bad_instruction;
    logic        write_enable;
    logic [7:0]  write_index;
    logic [7:0]  write_kind;
    logic [63:0] write_payload;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/bcje_ifs.sv =====
// Channel interfaces of the execute core: instruction, result and configuration.
// Plain valid/ready channels; no dependencies.
`default_nettype none

interface bcje_instr_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [3:0]  compare_type;
  logic [2:0]  relation;
  logic [7:0]  dest_index;
  logic [7:0]  src_index;
  logic [63:0] operand_c;
  logic [15:0] current_pc;

  modport source(output valid, kind, compare_type, relation, dest_index, src_index,
                 operand_c, current_pc, input ready);
  modport sink(input valid, kind, compare_type, relation, dest_index, src_index,
               operand_c, current_pc, output ready);
endinterface

interface bcje_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        halted;
  logic        bad_instruction;
  logic        write_enable;
  logic [7:0]  write_index;
  logic [7:0]  write_kind;
  logic [63:0] write_payload;

  modport source(output valid, next_pc, halted, bad_instruction, write_enable,
                 write_index, write_kind, write_payload, input ready);
  modport sink(input valid, next_pc, halted, bad_instruction, write_enable,
               write_index, write_kind, write_payload, output ready);
endinterface

interface bcje_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bcje_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
`default_nettype none

module bcje_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bcje_exec.sv =====
// Combinational execute step: compare, jump resolution and register write.
// Depends on bcje_pkg for the instruction, operand and result types.
`default_nettype none

module bcje_exec #(
  parameter int REGISTER_COUNT = 256,
  parameter int PC_BITS        = 16
) (
  input  wire bcje_pkg::instr_t   instr,
  input  wire bcje_pkg::operand_t opnd_a,
  input  wire bcje_pkg::operand_t opnd_b,
  input  wire logic [7:0]         bool_kind,
  output      bcje_pkg::result_t  res
);

  logic [PC_BITS-1:0] pc_w;
  logic [PC_BITS-1:0] pc_next;
  logic [PC_BITS-1:0] target;
  logic [3:0]         ct_m1;
  logic [63:0]        mask;
  logic [63:0]        sgn;
  logic [63:0]        am;
  logic [63:0]        bm;
  logic               rel_ok;
  logic               eq_only;
  logic               cmp_bad;
  logic               cmp_res;
  logic               cond_true;
  logic               taken;
  logic               we;
  logic [7:0]         wkind;
  logic [63:0]        wpay;
  logic               halt;
  logic               bad;
  logic               ra_in_range;

  assign pc_w   = PC_BITS'(instr.current_pc);
  assign target = instr.operand_c[PC_BITS-1:0];

  // Width mask and sign flip for the integer compares
  assign ct_m1 = instr.compare_type - 4'd1;
  always_comb begin
    case (ct_m1[1:0])
      2'd0: begin mask = 64'h0000_0000_0000_00FF; sgn = 64'h0000_0000_0000_0080; end
      2'd1: begin mask = 64'h0000_0000_0000_FFFF; sgn = 64'h0000_0000_0000_8000; end
      2'd2: begin mask = 64'h0000_0000_FFFF_FFFF; sgn = 64'h0000_0000_8000_0000; end
      default: begin mask = 64'hFFFF_FFFF_FFFF_FFFF; sgn = 64'h8000_0000_0000_0000; end
    endcase
  end

  // Bring both operands into one unsigned ordering
  always_comb begin
    if (instr.compare_type == bcje_pkg::CT_BOOL) begin
      am = {63'd0, (opnd_a.payload[7:0] != 8'd0)};
      bm = {63'd0, (opnd_b.payload[7:0] != 8'd0)};
    end else if (instr.compare_type == bcje_pkg::CT_HANDLE) begin
      am = opnd_a.payload;
      bm = opnd_b.payload;
    end else if (instr.compare_type <= bcje_pkg::CT_S64) begin
      am = (opnd_a.payload & mask) ^ sgn;
      bm = (opnd_b.payload & mask) ^ sgn;
    end else begin
      am = opnd_a.payload & mask;
      bm = opnd_b.payload & mask;
    end
  end

  // Relation and legality
  assign rel_ok  = instr.relation <= bcje_pkg::REL_GT;
  assign eq_only = (instr.compare_type == bcje_pkg::CT_BOOL) ||
                   (instr.compare_type == bcje_pkg::CT_HANDLE);
  assign cmp_bad = !rel_ok || (instr.compare_type > bcje_pkg::CT_HANDLE) ||
                   (eq_only && (instr.relation != bcje_pkg::REL_EQ) &&
                    (instr.relation != bcje_pkg::REL_NE));

  always_comb begin
    case (instr.relation)
      bcje_pkg::REL_LT: cmp_res = am < bm;
      bcje_pkg::REL_LE: cmp_res = am <= bm;
      bcje_pkg::REL_EQ: cmp_res = am == bm;
      bcje_pkg::REL_NE: cmp_res = am != bm;
      bcje_pkg::REL_GE: cmp_res = am >= bm;
      default:          cmp_res = am > bm;
    endcase
  end

  assign cond_true = (opnd_a.kind == bool_kind) && (opnd_a.payload != 64'd0);

  // Decode the instruction kind
  always_comb begin
    pc_next = pc_w + PC_BITS'(1);
    taken   = 1'b0;
    we      = 1'b0;
    wkind   = 8'd0;
    wpay    = 64'd0;
    halt    = 1'b0;
    bad     = 1'b0;
    case (instr.kind)
      bcje_pkg::OP_NOP: begin
      end
      bcje_pkg::OP_LOAD: begin
        we    = 1'b1;
        wkind = instr.src_index;
        wpay  = instr.operand_c;
      end
      bcje_pkg::OP_MOVE: begin
        we    = 1'b1;
        wkind = opnd_a.kind;
        wpay  = opnd_a.payload;
      end
      bcje_pkg::OP_CMP: begin
        bad   = cmp_bad;
        we    = !cmp_bad;
        wkind = bool_kind;
        wpay  = {63'd0, cmp_res};
      end
      bcje_pkg::OP_JMP:   taken = 1'b1;
      bcje_pkg::OP_JMP_F: taken = !cond_true;
      bcje_pkg::OP_JMP_T: taken = cond_true;
      bcje_pkg::OP_RETURN: begin
        halt    = 1'b1;
        pc_next = pc_w;
      end
      default: bad = 1'b1;
    endcase
    if (taken) begin
      pc_next = target;
    end
  end

  // Drop writes beyond the register file
  assign ra_in_range = {1'b0, instr.dest_index} < 9'(REGISTER_COUNT);

  always_comb begin
    res.next_pc         = 16'(pc_next);
    res.halted          = halt;
    res.bad_instruction = bad;
    if (we && ra_in_range) begin
      res.write_enable  = 1'b1;
      res.write_index   = instr.dest_index;
      res.write_kind    = wkind;
      res.write_payload = wpay;
    end else begin
      res.write_enable  = 1'b0;
      res.write_index   = 8'd0;
      res.write_kind    = 8'd0;
      res.write_payload = 64'd0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bytecode_compare_jump_execute_core.sv =====
// Top level of the bytecode compare/jump execute core.
// Depends on bcje_pkg, the channel interfaces, bcje_ram and bcje_exec.
`default_nettype none

// Takes one decoded instruction per clock while the result consumer keeps up and returns one
// result word for each: stage 1 captures the instruction and reads the register file, then the
// result register takes the result as the register write is committed. Sustained rate is one
// instruction per cycle, limited only by the result consumer. The register file is held in
// two RAM copies (one per read port, both written together); a write from the instruction
// ahead is forwarded to the one behind, so dependent instructions run back to back. Per-entry
// valid bits cleared by reset make the whole file read as zero after reset, so no clearing
// pass is needed and instructions are accepted straight out of reset. The
// configuration channel is always ready and registers each word as the bool kind code.
module bytecode_compare_jump_execute_core #(
  parameter int REGISTER_COUNT = 256,
  parameter int PC_BITS        = 16
) (
  input wire logic       clk,
  input wire logic       rst,
  bcje_instr_if.sink     instr,
  bcje_result_if.source  result,
  bcje_cfg_if.sink       cfg
);

  localparam int AW = $clog2(REGISTER_COUNT);

  logic [7:0]            bool_kind;
  logic                  accept;
  logic                  s1_valid;
  logic                  s1_adv;
  bcje_pkg::instr_t      s1_instr;
  bcje_pkg::instr_t      in_word;
  logic [7:0]            addr_a;
  logic [7:0]            addr_b;
  logic                  range_a;
  logic                  range_b;
  logic                  vld_a;
  logic                  vld_b;
  logic                  hit_a;
  logic                  hit_b;
  bcje_pkg::operand_t    fwd;
  logic [71:0]           ram_a;
  logic [71:0]           ram_b;
  bcje_pkg::operand_t    opnd_a;
  bcje_pkg::operand_t    opnd_b;
  bcje_pkg::result_t     res;
  bcje_pkg::result_t     out_q;
  logic                  out_valid;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [71:0]           wr_data;
  logic [REGISTER_COUNT-1:0] ent_vld;

  // Configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bool_kind <= bcje_pkg::BOOL_KIND_RESET;
    end else if (cfg.valid) begin
      bool_kind <= cfg.data;
    end
  end

  // Handshake: stage 1 advances into the result register when that is free
  assign s1_adv      = s1_valid && (!out_valid || result.ready);
  assign instr.ready = !s1_valid || s1_adv;
  assign accept      = instr.valid && instr.ready;

  assign in_word = '{kind: instr.kind, compare_type: instr.compare_type,
                     relation: instr.relation, dest_index: instr.dest_index,
                     src_index: instr.src_index, operand_c: instr.operand_c,
                     current_pc: instr.current_pc};

  // Read addresses: conditional jumps test field a, the rest read field b and c
  assign addr_a  = ((instr.kind == bcje_pkg::OP_JMP_F) || (instr.kind == bcje_pkg::OP_JMP_T)) ?
                   instr.dest_index : instr.src_index;
  assign addr_b  = instr.operand_c[7:0];
  assign range_a = {1'b0, addr_a} < 9'(REGISTER_COUNT);
  assign range_b = {1'b0, addr_b} < 9'(REGISTER_COUNT);

  // Stage 1: capture the instruction, valid bits and forwarding from the word ahead
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= in_word;
      vld_a    <= range_a ? ent_vld[addr_a[AW-1:0]] : 1'b0;
      vld_b    <= range_b ? ent_vld[addr_b[AW-1:0]] : 1'b0;
      hit_a    <= wr_en && (res.write_index == addr_a);
      hit_b    <= wr_en && (res.write_index == addr_b);
      fwd      <= wr_data;
    end
  end

  bcje_ram #(.WIDTH(72), .DEPTH(REGISTER_COUNT)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (addr_a[AW-1:0]),
    .rd_data (ram_a)
  );

  bcje_ram #(.WIDTH(72), .DEPTH(REGISTER_COUNT)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (addr_b[AW-1:0]),
    .rd_data (ram_b)
  );

  // Pick forwarded, stored or reset value for each operand
  always_comb begin
    if (hit_a) begin
      opnd_a = fwd;
    end else if (vld_a) begin
      opnd_a = ram_a;
    end else begin
      opnd_a = '0;
    end
    if (hit_b) begin
      opnd_b = fwd;
    end else if (vld_b) begin
      opnd_b = ram_b;
    end else begin
      opnd_b = '0;
    end
  end

  bcje_exec #(.REGISTER_COUNT(REGISTER_COUNT), .PC_BITS(PC_BITS)) u_exec (
    .instr     (s1_instr),
    .opnd_a    (opnd_a),
    .opnd_b    (opnd_b),
    .bool_kind (bool_kind),
    .res       (res)
  );

  // Commit the register write as the word leaves stage 1
  assign wr_en   = s1_adv && res.write_enable;
  assign wr_addr = res.write_index[AW-1:0];
  assign wr_data = {res.write_kind, res.write_payload};

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (wr_en) begin
      ent_vld[wr_addr] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign result.valid           = out_valid;
  assign result.next_pc         = out_q.next_pc;
  assign result.halted          = out_q.halted;
  assign result.bad_instruction = out_q.bad_instruction;
  assign result.write_enable    = out_q.write_enable;
  assign result.write_index     = out_q.write_index;
  assign result.write_kind      = out_q.write_kind;
  assign result.write_payload   = out_q.write_payload;

endmodule

`default_nettype wire

// ===== tb/bytecode_compare_jump_execute_core_tb.sv =====
// Self-checking testbench for the bytecode compare/jump execute core.
// Needs bcje_pkg, the channel interfaces in bcje_ifs.sv and the core itself.
`default_nettype none

module bytecode_compare_jump_execute_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcje_pkg::*;

  // Compare widths and the first unsupported kind not named in the package
  localparam logic [3:0] CT_S8          = 4'd1;
  localparam logic [3:0] CT_S16         = 4'd2;
  localparam logic [3:0] CT_S32         = 4'd3;
  localparam logic [3:0] CT_U8          = 4'd5;
  localparam logic [3:0] CT_U16         = 4'd6;
  localparam logic [3:0] CT_U32         = 4'd7;
  localparam logic [3:0] CT_U64         = 4'd8;
  localparam logic [3:0] OP_UNSUPPORTED = 4'd8;

  localparam int unsigned RANDOM_PER_PHASE = 232;
  localparam int unsigned HOLD_OFF_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned CYCLE_LIMIT      = 300000;
  localparam int unsigned PRINT_LIMIT      = 40;

  // Tracks the register file and bool kind code, and queues the expected result words
  class exec_result_tracker;
    logic [7:0]  reg_kind [256];
    logic [63:0] reg_payload [256];
    logic [7:0]  bool_kind;
    result_t     expected_results [$];
    int unsigned errors;
    int unsigned instrs_seen;
    int unsigned writes;
    int unsigned taken_jumps;
    int unsigned returns;
    int unsigned flagged_bad;

    function new();
      foreach (reg_kind[i]) begin
        reg_kind[i] = '0;
        reg_payload[i] = '0;
      end
      bool_kind = BOOL_KIND_RESET;
      errors = 0;
      instrs_seen = 0;
      writes = 0;
      taken_jumps = 0;
      returns = 0;
      flagged_bad = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void set_bool_kind(logic [7:0] code);
      bool_kind = code;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Extend the compared slice to 65 bits so one signed compare serves every width
    function logic signed [64:0] widen(logic [63:0] v, logic [3:0] ctype);
      case (ctype)
        CT_S8:   return {{57{v[7]}}, v[7:0]};
        CT_S16:  return {{49{v[15]}}, v[15:0]};
        CT_S32:  return {{33{v[31]}}, v[31:0]};
        CT_S64:  return {v[63], v};
        CT_U8:   return {57'd0, v[7:0]};
        CT_U16:  return {49'd0, v[15:0]};
        CT_U32:  return {33'd0, v[31:0]};
        default: return {1'b0, v};
      endcase
    endfunction

    function bit ordered(logic signed [64:0] a, logic signed [64:0] b, logic [2:0] rel);
      case (rel)
        REL_LT:  return a < b;
        REL_LE:  return a <= b;
        REL_EQ:  return a == b;
        REL_NE:  return a != b;
        REL_GE:  return a >= b;
        default: return a > b;
      endcase
    endfunction

    function bit cond_true(logic [7:0] idx);
      return reg_kind[idx] == bool_kind && reg_payload[idx] != 64'd0;
    endfunction

    // Work out the result word of one accepted instruction and update the register file
    function void note_instr(instr_t it);
      result_t r;
      logic [63:0] lhs;
      logic [63:0] rhs;
      bit truth;
      r = '0;
      truth = 1'b0;
      r.next_pc = it.current_pc + 16'd1;
      instrs_seen++;
      case (it.kind)
        OP_NOP: ;
        OP_LOAD: begin
          r.write_enable = 1'b1;
          r.write_kind = it.src_index;
          r.write_payload = it.operand_c;
        end
        OP_MOVE: begin
          r.write_enable = 1'b1;
          r.write_kind = reg_kind[it.src_index];
          r.write_payload = reg_payload[it.src_index];
        end
        OP_CMP: begin
          lhs = reg_payload[it.src_index];
          rhs = reg_payload[it.operand_c[7:0]];
          if (it.relation > REL_GT || it.compare_type > CT_HANDLE) begin
            r.bad_instruction = 1'b1;
          end else if (it.compare_type == CT_BOOL || it.compare_type == CT_HANDLE) begin
            // bool and handle compares only know equal and not equal
            if (it.relation != REL_EQ && it.relation != REL_NE) begin
              r.bad_instruction = 1'b1;
            end else begin
              if (it.compare_type == CT_BOOL) begin
                lhs = {63'd0, |lhs[7:0]};
                rhs = {63'd0, |rhs[7:0]};
              end
              truth = (it.relation == REL_EQ) == (lhs == rhs);
            end
          end else begin
            truth = ordered(widen(lhs, it.compare_type), widen(rhs, it.compare_type),
                            it.relation);
          end
          if (!r.bad_instruction) begin
            r.write_enable = 1'b1;
            r.write_kind = bool_kind;
            r.write_payload = {63'd0, truth};
          end
        end
        OP_JMP: begin
          r.next_pc = it.operand_c[15:0];
          taken_jumps++;
        end
        OP_JMP_F: begin
          if (!cond_true(it.dest_index)) begin
            r.next_pc = it.operand_c[15:0];
            taken_jumps++;
          end
        end
        OP_JMP_T: begin
          if (cond_true(it.dest_index)) begin
            r.next_pc = it.operand_c[15:0];
            taken_jumps++;
          end
        end
        OP_RETURN: begin
          r.halted = 1'b1;
          r.next_pc = it.current_pc;
          returns++;
        end
        default: r.bad_instruction = 1'b1;
      endcase
      if (r.bad_instruction) flagged_bad++;
      // Commit the write; every 8-bit index lies inside the file
      if (r.write_enable) begin
        r.write_index = it.dest_index;
        reg_kind[it.dest_index] = r.write_kind;
        reg_payload[it.dest_index] = r.write_payload;
        writes++;
      end
      expected_results.insert(expected_results.size(), r);
    endfunction

    // Compare one result word with the oldest expectation, field by field
    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result word with nothing expected, next_pc %h", got.next_pc));
        return;
      end
      want = expected_results.pop_front();
      if (got.next_pc !== want.next_pc)
        report($sformatf("next_pc %h, expected %h", got.next_pc, want.next_pc));
      if (got.halted !== want.halted)
        report($sformatf("halted %b, expected %b", got.halted, want.halted));
      if (got.bad_instruction !== want.bad_instruction)
        report($sformatf("bad_instruction %b, expected %b", got.bad_instruction,
                         want.bad_instruction));
      if (got.write_enable !== want.write_enable)
        report($sformatf("write_enable %b, expected %b", got.write_enable,
                         want.write_enable));
      if (got.write_index !== want.write_index)
        report($sformatf("write_index %h, expected %h", got.write_index, want.write_index));
      if (got.write_kind !== want.write_kind)
        report($sformatf("write_kind %h, expected %h", got.write_kind, want.write_kind));
      if (got.write_payload !== want.write_payload)
        report($sformatf("write_payload %h, expected %h", got.write_payload,
                         want.write_payload));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bcje_instr_if  instr_ch();
  bcje_result_if result_ch();
  bcje_cfg_if    cfg_ch();

  bytecode_compare_jump_execute_core dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  exec_result_tracker tracker;
  logic [7:0]  bool_code_now = BOOL_KIND_RESET;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_cycle = 0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: stall on a rotating pattern, or hold off for a long stretch on request
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_OFF_CYCLES;
      result_ch.ready <= 1'b0;
    end else begin
      case (stall_cycle[8:6])
        3'd0, 3'd1: result_ch.ready <= 1'b1;
        3'd2, 3'd3: result_ch.ready <= 1'($urandom_range(0, 1));
        3'd4:       result_ch.ready <= (stall_cycle[1:0] == 2'd0);
        3'd5:       result_ch.ready <= ($urandom_range(0, 9) != 0);
        default:    result_ch.ready <= stall_cycle[3];
      endcase
    end
  end

  // Watch every channel at the clock edge and hand the words to the tracker
  always @(posedge clk) begin : watch
    instr_t  seen;
    result_t got;
    if (!rst && tracker != null) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.set_bool_kind(cfg_ch.data);
      if (instr_ch.valid && instr_ch.ready) begin
        seen.kind         = instr_ch.kind;
        seen.compare_type = instr_ch.compare_type;
        seen.relation     = instr_ch.relation;
        seen.dest_index   = instr_ch.dest_index;
        seen.src_index    = instr_ch.src_index;
        seen.operand_c    = instr_ch.operand_c;
        seen.current_pc   = instr_ch.current_pc;
        tracker.note_instr(seen);
      end
      if (result_ch.valid && result_ch.ready) begin
        got.next_pc         = result_ch.next_pc;
        got.halted          = result_ch.halted;
        got.bad_instruction = result_ch.bad_instruction;
        got.write_enable    = result_ch.write_enable;
        got.write_index     = result_ch.write_index;
        got.write_kind      = result_ch.write_kind;
        got.write_payload   = result_ch.write_payload;
        tracker.check_result(got);
      end
    end
  end

  // Offer one instruction word and hold it until accepted; valid stays high
  task automatic send_instr(input instr_t it);
    instr_ch.valid        <= 1'b1;
    instr_ch.kind         <= it.kind;
    instr_ch.compare_type <= it.compare_type;
    instr_ch.relation     <= it.relation;
    instr_ch.dest_index   <= it.dest_index;
    instr_ch.src_index    <= it.src_index;
    instr_ch.operand_c    <= it.operand_c;
    instr_ch.current_pc   <= it.current_pc;
    do @(posedge clk); while (!instr_ch.ready);
  endtask

  task automatic idle_instr(input int unsigned cycles);
    instr_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering until every expected result word is back, then let the pipe settle
  task automatic wait_drained();
    instr_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bool_kind(input logic [7:0] code);
    cfg_ch.data  <= code;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    bool_code_now = code;
  endtask

  function automatic instr_t mk(logic [3:0] kind, logic [3:0] ctype, logic [2:0] rel,
                                logic [7:0] a, logic [7:0] b, logic [63:0] c,
                                logic [15:0] pc);
    instr_t it;
    it.kind = kind;
    it.compare_type = ctype;
    it.relation = rel;
    it.dest_index = a;
    it.src_index = b;
    it.operand_c = c;
    it.current_pc = pc;
    return it;
  endfunction

  // Mostly a small window of registers so that values get reused
  function automatic logic [7:0] pick_reg();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  // Payloads biased towards the sign and width boundaries
  function automatic logic [63:0] pick_payload();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return 64'($urandom_range(0, 3));
      5: return {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00;
      6: begin
        case ($urandom_range(0, 5))
          0: return 64'h80;
          1: return 64'h7F;
          2: return 64'h8000;
          3: return 64'hFFFF;
          4: return 64'h8000_0000;
          default: return 64'hFFFF_FFFF;
        endcase
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    int unsigned pick;
    it = mk(OP_NOP, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), pick_reg(),
            pick_reg(), {$urandom, $urandom},
            ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.kind = OP_LOAD;
      it.src_index = $urandom_range(0, 1) ? bool_code_now : 8'($urandom);
      it.operand_c = pick_payload();
    end else if (pick < 35) begin
      it.kind = OP_MOVE;
    end else if (pick < 70) begin
      it.kind = OP_CMP;
      it.compare_type = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                    : 4'($urandom_range(0, 9));
      if ((it.compare_type == CT_BOOL || it.compare_type == CT_HANDLE) &&
          $urandom_range(0, 9) < 7)
        it.relation = $urandom_range(0, 1) ? REL_EQ : REL_NE;
      else
        it.relation = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5));
      it.operand_c[7:0] = pick_reg();
    end else if (pick < 74) begin
      it.kind = OP_JMP;
    end else if (pick < 80) begin
      it.kind = OP_JMP_F;
    end else if (pick < 86) begin
      it.kind = OP_JMP_T;
    end else if (pick < 89) begin
      it.kind = OP_RETURN;
    end else if (pick < 93) begin
      it.kind = OP_NOP;
    end else begin
      it.kind = 4'($urandom_range(OP_UNSUPPORTED, 15));
    end
    return it;
  endfunction

  // Directed words: field extremes, every operation, illegal compares, wrapping pc
  task automatic run_directed();
    send_instr(mk(OP_LOAD, CT_BOOL, REL_LT, 8'd0, BOOL_KIND_RESET, 64'd1, 16'h0000));
    send_instr(mk(OP_LOAD, CT_BOOL, REL_LT, 8'd1, 8'hFF, '1, 16'h0001));
    send_instr(mk(OP_LOAD, CT_BOOL, REL_LT, 8'd2, 8'h00, 64'h8000_0000_0000_0000, 16'h0002));
    send_instr(mk(OP_LOAD, CT_BOOL, REL_LT, 8'd255, 8'h80, 64'h7FFF_FFFF_FFFF_FFFF,
                  16'h0003));
    send_instr(mk(OP_MOVE, CT_BOOL, REL_LT, 8'd3, 8'd1, 64'd0, 16'h0004));
    send_instr(mk(OP_MOVE, CT_BOOL, REL_LT, 8'd254, 8'd255, 64'd0, 16'h0005));
    send_instr(mk(OP_CMP, CT_S8, REL_LT, 8'd4, 8'd1, 64'd2, 16'h0006));
    send_instr(mk(OP_CMP, CT_U64, REL_GT, 8'd5, 8'd1, 64'd2, 16'h0007));
    send_instr(mk(OP_CMP, CT_S64, REL_LE, 8'd6, 8'd2, 64'd255, 16'h0008));
    send_instr(mk(OP_CMP, CT_S16, REL_GE, 8'd9, 8'd255, 64'hFFFF_FFFF_FFFF_FF01, 16'h0009));
    send_instr(mk(OP_CMP, CT_S32, REL_NE, 8'd10, 8'd2, 64'd3, 16'h000A));
    send_instr(mk(OP_CMP, CT_U8, REL_EQ, 8'd11, 8'd1, 64'd255, 16'h000B));
    send_instr(mk(OP_CMP, CT_U16, REL_LT, 8'd12, 8'd255, 64'd1, 16'h000C));
    send_instr(mk(OP_CMP, CT_U32, REL_GE, 8'd13, 8'd2, 64'd0, 16'h000D));
    send_instr(mk(OP_CMP, CT_BOOL, REL_EQ, 8'd7, 8'd0, 64'd1, 16'h000E));
    send_instr(mk(OP_CMP, CT_HANDLE, REL_NE, 8'd8, 8'd1, 64'd3, 16'h000F));
    // bool and handle with an ordering relation, unknown type, unknown relation
    send_instr(mk(OP_CMP, CT_BOOL, REL_LT, 8'd14, 8'd0, 64'd1, 16'h0010));
    send_instr(mk(OP_CMP, CT_HANDLE, REL_GT, 8'd14, 8'd0, 64'd1, 16'h0011));
    send_instr(mk(OP_CMP, 4'd15, REL_EQ, 8'd14, 8'd0, 64'd1, 16'h0012));
    send_instr(mk(OP_CMP, CT_S64, 3'd7, 8'd14, 8'd0, 64'd1, 16'h0013));
    send_instr(mk(OP_JMP, CT_BOOL, REL_LT, 8'd0, 8'd0, 64'hFFFF_FFFF_FFFF_ABCD, 16'h0014));
    // condition true, condition of a foreign kind, written bool true, kind zero
    send_instr(mk(OP_JMP_F, CT_BOOL, REL_LT, 8'd0, 8'd0, 64'h1234, 16'h0015));
    send_instr(mk(OP_JMP_F, CT_BOOL, REL_LT, 8'd1, 8'd0, 64'h5678, 16'h0016));
    send_instr(mk(OP_JMP_T, CT_BOOL, REL_LT, 8'd7, 8'd0, 64'h9ABC, 16'h0017));
    send_instr(mk(OP_JMP_T, CT_BOOL, REL_LT, 8'd2, 8'd0, 64'hDEF0, 16'h0018));
    send_instr(mk(OP_RETURN, CT_BOOL, REL_LT, 8'd0, 8'd0, 64'd0, 16'h1234));
    send_instr(mk(4'd15, 4'd15, 3'd7, 8'hFF, 8'hFF, '1, 16'hFFFF));
    send_instr(mk(OP_NOP, CT_BOOL, REL_LT, 8'd0, 8'd0, 64'd0, 16'hFFFF));
  endtask

  // Random words in bursts with gaps; optionally a long receiver hold-off or a mid drain
  task automatic run_random(input int unsigned count, input bit long_hold,
                            input bit mid_drain);
    int unsigned sent;
    int unsigned burst_left;
    sent = 0;
    burst_left = 0;
    while (sent < count) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) idle_instr($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 16);
      end
      send_instr(random_instr());
      sent++;
      burst_left--;
      // keep offering back to back while the receiver holds off
      if (long_hold && sent == 40) begin
        hold_requests <= hold_requests + 1;
        burst_left = 40;
      end
      if (mid_drain && sent == count / 2) begin
        wait_drained();
        burst_left = 0;
      end
    end
  endtask

  initial begin : stimulus
    instr_ch.valid        <= 1'b0;
    instr_ch.kind         <= OP_NOP;
    instr_ch.compare_type <= CT_BOOL;
    instr_ch.relation     <= REL_LT;
    instr_ch.dest_index   <= '0;
    instr_ch.src_index    <= '0;
    instr_ch.operand_c    <= '0;
    instr_ch.current_pc   <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.data           <= '0;
    tracker = new();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_bool_kind(BOOL_KIND_RESET);
    run_directed();
    wait_drained();

    // One phase per bool kind code, extremes included
    write_bool_kind(8'h00);
    run_random(RANDOM_PER_PHASE, 1'b0, 1'b0);
    wait_drained();
    write_bool_kind(8'hFF);
    run_random(RANDOM_PER_PHASE, 1'b1, 1'b0);
    wait_drained();
    write_bool_kind(8'($urandom_range(2, 254)));
    run_random(RANDOM_PER_PHASE, 1'b0, 1'b1);
    wait_drained();
    write_bool_kind(BOOL_KIND_RESET);
    run_random(RANDOM_PER_PHASE, 1'b0, 1'b0);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Covered %0d instructions over five bool kind phases: %0d register writes,",
             tracker.instrs_seen, tracker.writes);
    $display("  %0d taken jumps, %0d returns, %0d illegal words; %0d mismatches.",
             tracker.taken_jumps, tracker.returns, tracker.flagged_bad, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
